// ----- design/pfa_pkg.sv -----
// Shared constants and types for the partition fit allocator.
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int unsigned NUM_PARTITIONS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF      = 16;

  localparam int unsigned AMOUNT_W   = 16;
  localparam int unsigned PIDX_W     = 4;
  localparam int unsigned PIU_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [PIU_W-1:0] PIU_RESET = 5'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_STRATEGY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTS_IN_USE = 2'd1;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_e;

endpackage

// ----- design/pfa_cap_mem.sv -----
// Free capacity table: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module pfa_cap_mem #(
  parameter int unsigned DEPTH = pfa_pkg::NUM_PARTITIONS_DEF,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = pfa_pkg::SIZE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/partition_fit_allocator_unit.sv -----
// Top level of the partition fit allocator: control, search sequencer, registers.
// Load beat: written in the accept cycle (index in range), no result, busy stays low.
// Allocate beat: n = min(partitions_in_use, NUM_PARTITIONS) capacity reads, one per
//   cycle from the single read port; each read is registered and judged, and the
//   result is registered as a strobe; busy drops with it. n = 0: refused, no search.
// Results are one-cycle strobes; the receiver cannot stall them.
// Reset clears control, strategy (first fit), partition count (16) and rover (0);
//   the capacity table is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps

module partition_fit_allocator_unit #(
  parameter int unsigned NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEF,
  parameter int unsigned SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic                             req_type_i,
  input  logic [pfa_pkg::PIDX_W-1:0]       partition_index_i,
  input  logic [pfa_pkg::AMOUNT_W-1:0]     amount_i,
  // result strobe
  output logic                             valid_o,
  output logic                             granted_o,
  output logic [pfa_pkg::PIDX_W-1:0]       granted_partition_o
);

  localparam int unsigned AW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned PW = pfa_pkg::PIDX_W;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // configuration registers
  pfa_pkg::fit_e                strat_q;
  logic [pfa_pkg::PIU_W-1:0]    piu_q;

  // sequencer state
  state_e                       state_q, state_d;
  logic [AW-1:0]                rover_q, rover_d;
  logic [SIZE_BITS-1:0]         req_q, req_d;
  logic [CW-1:0]                n_q, n_d;
  logic [AW-1:0]                scan_pos_q, scan_pos_d;
  logic [CW-1:0]                scan_left_q, scan_left_d;
  logic                         chk_vld_q, chk_vld_d;
  logic                         chk_last_q, chk_last_d;
  logic [AW-1:0]                chk_pos_q, chk_pos_d;
  logic                         found_q, found_d;
  logic [AW-1:0]                sel_q, sel_d;
  logic [SIZE_BITS-1:0]         sel_cap_q, sel_cap_d;
  logic                         res_vld_q, res_vld_d;
  logic                         res_grant_q, res_grant_d;
  logic [PW-1:0]                res_part_q, res_part_d;

  // memory port
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [SIZE_BITS-1:0]         mem_wdata;
  logic                         mem_re;
  logic [SIZE_BITS-1:0]         rd_data;

  // datapath helpers
  logic                         accept;
  logic                         load_in_range;
  logic [CW-1:0]                n_now;
  logic [AW-1:0]                start_pos;
  logic [AW-1:0]                pos_next;
  logic                         fits;
  logic                         better;
  logic                         take;
  logic                         scan_done;
  logic                         fin_found;
  logic [AW-1:0]                fin_sel;
  logic [SIZE_BITS-1:0]         fin_cap;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;

  // Configuration must only be written while idle; the block does not enforce this and takes every beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strat_q <= pfa_pkg::FIT_FIRST;
      piu_q   <= pfa_pkg::PIU_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pfa_pkg::REG_FIT_STRATEGY: strat_q <= pfa_pkg::fit_e'(cfg_data_i[1:0]);
        pfa_pkg::REG_PARTS_IN_USE: piu_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the searched count to the table depth.
  assign n_now = (32'(piu_q) >= NUM_PARTITIONS) ? CW'(NUM_PARTITIONS) : CW'(piu_q);

  // Next fit starts at the rover unless it lies past the searched range.
  assign start_pos = ((strat_q == pfa_pkg::FIT_NEXT) && (CW'(rover_q) < n_now)) ?
                     rover_q : '0;

  assign load_in_range = (32'(partition_index_i) < NUM_PARTITIONS);

  // Advance the read pointer with wrap at the searched count.
  assign pos_next = ((CW'(scan_pos_q) + CW'(1)) == n_q) ? '0 : scan_pos_q + AW'(1);

  // Evaluate the entry that came back from the table this cycle.
  assign fits   = (rd_data >= req_q);
  assign better = ((strat_q == pfa_pkg::FIT_BEST)  && (rd_data < sel_cap_q)) ||
                  ((strat_q == pfa_pkg::FIT_WORST) && (rd_data > sel_cap_q));
  assign take   = chk_vld_q && fits && (!found_q || better);

  // The last returned entry closes the search; fold its decision in directly.
  assign scan_done = chk_vld_q && chk_last_q;
  assign fin_found = found_q || take;
  assign fin_sel   = take ? chk_pos_q : sel_q;
  assign fin_cap   = take ? rd_data : sel_cap_q;

  // Table write: load beat while idle, or the granted entry when the search closes.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fin_sel;
    mem_wdata = fin_cap - req_q;
    if (state_q == ST_IDLE) begin
      mem_we    = accept && (req_type_i == pfa_pkg::REQ_LOAD) && load_in_range;
      mem_waddr = AW'(partition_index_i);
      mem_wdata = SIZE_BITS'(amount_i);
    end else begin
      mem_we = scan_done && fin_found;
    end
  end

  assign mem_re = (state_q == ST_SCAN) && (scan_left_q != '0);

  pfa_cap_mem #(
    .DEPTH (NUM_PARTITIONS),
    .AW    (AW),
    .DW    (SIZE_BITS)
  ) u_cap_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (scan_pos_q),
    .rdata_o (rd_data)
  );

  // Search sequencer: issue one read per cycle, judge each entry in the next cycle.
  always_comb begin
    state_d     = state_q;
    rover_d     = rover_q;
    req_d       = req_q;
    n_d         = n_q;
    scan_pos_d  = scan_pos_q;
    scan_left_d = scan_left_q;
    chk_vld_d   = 1'b0;
    chk_last_d  = 1'b0;
    chk_pos_d   = chk_pos_q;
    found_d     = found_q;
    sel_d       = sel_q;
    sel_cap_d   = sel_cap_q;
    res_vld_d   = 1'b0;
    res_grant_d = res_grant_q;
    res_part_d  = res_part_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == pfa_pkg::REQ_LOAD) begin
            rover_d = '0;
          end else if (n_now == '0) begin
            // nothing to search: refuse at once
            res_vld_d   = 1'b1;
            res_grant_d = 1'b0;
            res_part_d  = '0;
          end else begin
            state_d     = ST_SCAN;
            req_d       = SIZE_BITS'(amount_i);
            n_d         = n_now;
            scan_pos_d  = start_pos;
            scan_left_d = n_now;
            found_d     = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_left_q != '0) begin
          chk_vld_d   = 1'b1;
          chk_last_d  = (scan_left_q == CW'(1));
          chk_pos_d   = scan_pos_q;
          scan_pos_d  = pos_next;
          scan_left_d = scan_left_q - CW'(1);
        end
        if (take) begin
          found_d   = 1'b1;
          sel_d     = chk_pos_q;
          sel_cap_d = rd_data;
        end
        if (scan_done) begin
          state_d     = ST_IDLE;
          res_vld_d   = 1'b1;
          res_grant_d = fin_found;
          res_part_d  = fin_found ? PW'(fin_sel) : '0;
          // next fit leaves the rover on the granted partition
          if (fin_found && (strat_q == pfa_pkg::FIT_NEXT)) begin
            rover_d = fin_sel;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rover_q     <= '0;
      scan_left_q <= '0;
      chk_vld_q   <= 1'b0;
      chk_last_q  <= 1'b0;
      found_q     <= 1'b0;
      res_vld_q   <= 1'b0;
      res_grant_q <= 1'b0;
      res_part_q  <= '0;
    end else begin
      state_q     <= state_d;
      rover_q     <= rover_d;
      scan_left_q <= scan_left_d;
      chk_vld_q   <= chk_vld_d;
      chk_last_q  <= chk_last_d;
      found_q     <= found_d;
      res_vld_q   <= res_vld_d;
      res_grant_q <= res_grant_d;
      res_part_q  <= res_part_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    n_q        <= n_d;
    scan_pos_q <= scan_pos_d;
    chk_pos_q  <= chk_pos_d;
    sel_q      <= sel_d;
    sel_cap_q  <= sel_cap_d;
  end

  assign valid_o             = res_vld_q;
  assign granted_o           = res_grant_q;
  assign granted_partition_o = res_part_q;

  // A result never shows while a search is still running.
  a_strobe_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe raised during a search");

  // A load beat leaves the block idle and silent.
  a_load_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == pfa_pkg::REQ_LOAD)) |=> (!busy && !valid_o))
    else $error("load beat started a search or produced a result");

  // An allocate beat either searches or answers at once.
  a_alloc_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == pfa_pkg::REQ_ALLOC)) |=> (busy || valid_o))
    else $error("allocate beat dropped");

  // A result ends every search: leaving the scan state raises the strobe.
  a_scan_ends_in_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("search ended without a result");

endmodule
